[design/bclk_pkg.sv]
// Shared types and constants for the BCD alarm clock core.
// Holds the queue item, the result layout and the action codes; no dependencies.
package bclk_pkg;

   // Default number of alarm entries
   localparam int ALARM_COUNT_DEF = 4;

   // Field widths of one request, the queue item and the fire masks
   localparam int MODE_W    = 3;
   localparam int IDX_IN_W  = 2;
   localparam int REG_W     = 8;
   localparam int HOURS_W   = 6;
   localparam int MINUTES_W = 7;
   localparam int FIRE_W    = 4;

   // Request tdata layout: alarm_sel, hours_reg, minutes_reg, zero fill
   localparam int HOURS_LSB   = IDX_IN_W;
   localparam int MINUTES_LSB = IDX_IN_W + REG_W;
   localparam int REQ_DATA_W  = ((IDX_IN_W + 2 * REG_W + 7) / 8) * 8;

   // Depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // Left digit pair shown while an alarm mode is displayed
   localparam logic [7:0] DISP_MODE_TAG = 8'h0A;

   // Action codes, equal to the request mode field
   typedef enum logic [MODE_W-1:0] {
      OP_TIME_READ     = 3'd0,
      OP_ALM_HOUR_UP   = 3'd1,
      OP_ALM_MIN_UP    = 3'd2,
      OP_ALM_MODE_UP   = 3'd3,
      OP_ALM_MODE_DOWN = 3'd4,
      OP_ALM_VIEW      = 3'd5,
      OP_TIME_HOUR_UP  = 3'd6,
      OP_TIME_MIN_UP   = 3'd7
   } op_type;

   // One classified action waiting for the back end
   typedef struct packed {
      op_type                 op;
      logic [IDX_IN_W-1:0]    idx;
      logic [HOURS_W-1:0]     hours;
      logic [MINUTES_W-1:0]   minutes;
   } item_type;

   // Result tdata layout, lowest field last
   typedef struct packed {
      logic [MINUTES_W-1:0] write_minutes;
      logic [HOURS_W-1:0]   write_hours;
      logic [FIRE_W-1:0]    radio_fire;
      logic [FIRE_W-1:0]    buzzer_fire;
      logic                 auto_flag;
      logic                 pm_flag;
      logic                 colon_flag;
      logic [7:0]           display_low;
      logic [7:0]           display_high;
   } rsp_data_type;

   localparam int RSP_DATA_W = $bits(rsp_data_type);

   // Full result transaction
   typedef struct packed {
      logic         write_valid;
      rsp_data_type data;
   } rsp_type;

endpackage

[design/bclk_front.sv]
// Front end: accepts request transactions, masks the clock bytes and folds
// the alarm index into range. Depends on bclk_pkg.
module bclk_front
   import bclk_pkg::*;
#(
   parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   localparam int CNT_BITS  = $clog2(ALARM_COUNT + 1);
   localparam int RED_W     = (CNT_BITS > IDX_IN_W) ? CNT_BITS : IDX_IN_W;
   localparam int RED_STEPS = (2 ** IDX_IN_W) - 1;

   logic [RED_W-1:0] idx_red;

   // Fold the alarm index below the alarm count by repeated subtraction
   always_comb begin
      idx_red = RED_W'(req_tdata[IDX_IN_W-1:0]);
      for (int k = 0; k < RED_STEPS; k++) begin
         if (idx_red >= RED_W'(ALARM_COUNT)) begin
            idx_red = idx_red - RED_W'(ALARM_COUNT);
         end
      end
   end

   // Build the queue item
   always_comb begin
      q_item.op      = op_type'(req_tuser);
      q_item.idx     = idx_red[IDX_IN_W-1:0];
      q_item.hours   = req_tdata[HOURS_LSB +: HOURS_W];
      q_item.minutes = req_tdata[MINUTES_LSB +: MINUTES_W];
   end

   // Take a transaction whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

[design/bclk_fifo.sv]
// Short register queue between the front end and the back end.
// Depends on bclk_pkg for the item type and depth.
module bclk_fifo
   import bclk_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item; clear the slots so an empty queue shows a known item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/bclk_back.sv]
// Back end: holds the alarm table, last time and display format; executes one queued
// action per cycle into the result register while it is free or being taken. Depends on bclk_pkg.
module bclk_back
   import bclk_pkg::*;
#(
   parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam int IDX_W  = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
   localparam int FIRE_N = (ALARM_COUNT < FIRE_W) ? ALARM_COUNT : FIRE_W;

   localparam logic [1:0] AM_OFF    = 2'd0;
   localparam logic [1:0] AM_BUZZER = 2'd1;
   localparam logic [1:0] AM_RADIO  = 2'd2;

   localparam logic [7:0] HOUR_MAX  = 8'h23;
   localparam logic [7:0] MIN_MAX   = 8'h59;
   localparam logic [7:0] CODE_BUZ  = 8'h0B;
   localparam logic [7:0] CODE_RAD  = 8'h0F;

   localparam logic [HOURS_W-1:0]   H_NOON  = 6'h12;
   localparam logic [HOURS_W-1:0]   H_DAY   = 6'h24;
   localparam logic [HOURS_W-1:0]   H_20    = 6'h20;
   localparam logic [HOURS_W-1:0]   H_21    = 6'h21;
   localparam logic [HOURS_W-1:0]   H_18    = 6'h18;
   localparam logic [MINUTES_W-1:0] M_LAST  = 7'h59;

   // BCD carry into the tens digit, then wrap past the limit
   function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] limit);
      logic [7:0] r;
      r = v;
      if (r[3:0] >= 4'hA) begin
         r = r + 8'h06;
      end
      if (r > limit) begin
         r = 8'h00;
      end
      return r;
   endfunction

   logic [HOURS_W-1:0]   alarm_hours_ff   [ALARM_COUNT];
   logic [MINUTES_W-1:0] alarm_minutes_ff [ALARM_COUNT];
   logic [1:0]           alarm_modes_ff   [ALARM_COUNT];
   logic [HOURS_W-1:0]   last_hours_ff;
   logic [MINUTES_W-1:0] last_minutes_ff;
   logic                 hour_form_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [IDX_W-1:0]     idx;
   logic [HOURS_W-1:0]   sel_h, step_h, show_h, fmt_h;
   logic [MINUTES_W-1:0] sel_m, step_m, show_m, fmt_m;
   logic [1:0]           sel_md, new_md;
   logic [7:0]           step_h_full, step_m_full, wr_h_full, wr_m_full;
   logic                 pm, any_on;
   logic [FIRE_W-1:0]    buz, rad;
   logic [FIRE_W-1:0]    hit;

   assign idx   = IDX_W'(q_item.idx);
   assign sel_h  = alarm_hours_ff[idx];
   assign sel_m  = alarm_minutes_ff[idx];
   assign sel_md = alarm_modes_ff[idx];

   // Execute when an action waits and the result register is free
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Step the selected alarm time and the time to write back
   always_comb begin
      step_h_full = bcd_step(8'(sel_h) + 8'd1, HOUR_MAX);
      step_m_full = bcd_step(8'(sel_m) + 8'd1, MIN_MAX);
      wr_h_full   = bcd_step(8'(q_item.hours) + 8'((q_item.op == OP_TIME_HOUR_UP) ? 1 : 0),
                             HOUR_MAX);
      wr_m_full   = bcd_step(8'(q_item.minutes) + 8'((q_item.op == OP_TIME_MIN_UP) ? 1 : 0),
                             MIN_MAX);
      step_h      = step_h_full[HOURS_W-1:0];
      step_m      = step_m_full[MINUTES_W-1:0];
   end

   // Cycle the alarm mode
   always_comb begin
      if (q_item.op == OP_ALM_MODE_UP) begin
         new_md = (sel_md >= AM_RADIO) ? AM_OFF : sel_md + 2'd1;
      end else begin
         new_md = (sel_md == AM_OFF) ? AM_RADIO : sel_md - 2'd1;
      end
   end

   // Check whether any alarm is on
   always_comb begin
      any_on = 1'b0;
      for (int i = 0; i < ALARM_COUNT; i++) begin
         any_on = any_on || (alarm_modes_ff[i] != AM_OFF);
      end
   end

   // Match enabled alarms against the new time; fire only if hour and minute both differ from the last time
   always_comb begin
      hit = '0;
      buz = '0;
      rad = '0;
      for (int i = 0; i < FIRE_N; i++) begin
         hit[i] = (alarm_hours_ff[i] == q_item.hours) &&
                  (alarm_hours_ff[i] != last_hours_ff) &&
                  (alarm_minutes_ff[i] == q_item.minutes) &&
                  (alarm_minutes_ff[i] != last_minutes_ff) &&
                  (alarm_modes_ff[i] != AM_OFF);
         buz[i] = hit[i] && (alarm_modes_ff[i] == AM_BUZZER);
         rad[i] = hit[i] && (alarm_modes_ff[i] != AM_BUZZER);
      end
   end

   // Pick the time to display
   always_comb begin
      unique case (q_item.op)
         OP_TIME_READ: begin
            show_h = q_item.hours;
            show_m = q_item.minutes;
         end
         OP_ALM_HOUR_UP: begin
            show_h = step_h;
            show_m = sel_m;
         end
         OP_ALM_MIN_UP: begin
            show_h = sel_h;
            show_m = step_m;
         end
         default: begin
            show_h = sel_h;
            show_m = sel_m;
         end
      endcase
   end

   // Format hours for 12- or 24-hour display; minutes past 59 show as zero
   always_comb begin
      pm    = 1'b0;
      fmt_h = show_h;
      if (hour_form_ff) begin
         if (show_h >= H_DAY) begin
            fmt_h = '0;
         end
      end else begin
         pm = (show_h >= H_NOON);
         if (show_h == '0) begin
            fmt_h = H_NOON;
         end else if (show_h == H_20 || show_h == H_21) begin
            fmt_h = show_h - H_18;
         end else if (show_h > H_NOON) begin
            fmt_h = show_h - H_NOON;
         end
      end
      fmt_m = (show_m > M_LAST) ? '0 : show_m;
   end

   // Assemble the result
   always_comb begin
      rsp_in = '0;
      unique case (q_item.op)
         OP_TIME_READ, OP_ALM_HOUR_UP, OP_ALM_MIN_UP, OP_ALM_VIEW: begin
            rsp_in.data.display_high = 8'(fmt_h);
            rsp_in.data.display_low  = 8'(fmt_m);
            rsp_in.data.colon_flag   = 1'b1;
            rsp_in.data.pm_flag      = pm;
            rsp_in.data.auto_flag    = any_on;
            if (q_item.op == OP_TIME_READ) begin
               rsp_in.data.buzzer_fire = buz;
               rsp_in.data.radio_fire  = rad;
            end
         end
         OP_ALM_MODE_UP, OP_ALM_MODE_DOWN: begin
            rsp_in.data.display_high = DISP_MODE_TAG;
            rsp_in.data.display_low  = (new_md == AM_OFF)    ? 8'h00 :
                                       (new_md == AM_BUZZER) ? CODE_BUZ : CODE_RAD;
            rsp_in.data.auto_flag    = (new_md != AM_OFF);
         end
         OP_TIME_HOUR_UP, OP_TIME_MIN_UP: begin
            rsp_in.write_valid        = 1'b1;
            rsp_in.data.write_hours   = wr_h_full[HOURS_W-1:0];
            rsp_in.data.write_minutes = wr_m_full[MINUTES_W-1:0];
         end
      endcase
   end

   // Hold the result until taken, refill on execute
   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Update the alarm table, last time and format register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALARM_COUNT; i++) begin
            alarm_hours_ff[i]   <= '0;
            alarm_minutes_ff[i] <= '0;
            alarm_modes_ff[i]   <= AM_OFF;
         end
         last_hours_ff   <= '0;
         last_minutes_ff <= '0;
         hour_form_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            hour_form_ff <= csr_wr_data;
         end
         if (q_pop) begin
            unique case (q_item.op)
               OP_TIME_READ: begin
                  last_hours_ff   <= q_item.hours;
                  last_minutes_ff <= q_item.minutes;
               end
               OP_ALM_HOUR_UP:                   alarm_hours_ff[idx]   <= step_h;
               OP_ALM_MIN_UP:                    alarm_minutes_ff[idx] <= step_m;
               OP_ALM_MODE_UP, OP_ALM_MODE_DOWN: alarm_modes_ff[idx]   <= new_md;
               OP_ALM_VIEW, OP_TIME_HOUR_UP, OP_TIME_MIN_UP: begin
               end
            endcase
         end
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[design/bcd_alarm_clock_core.sv]
// Top level of the BCD alarm clock core: front end, queue and back end.
// Depends on bclk_pkg, bclk_front, bclk_fifo and bclk_back.
//
// Each request transaction is one action (time reading, alarm edit, alarm
// view or time increment, selected by req_tuser) and yields exactly one
// response transaction, in order. The core sustains one action per clock
// cycle while the response side is ready: the back end reads and updates its
// alarm table once per cycle, and a two-entry queue between the front end and
// the back end lets intake and execution stall separately. A request passes
// through the queue register, then the result register, before its response
// is presented. Alarm state is in flip-flops cleared by reset, so the core
// takes requests right after reset. The hour form (0 twelve-hour with PM flag,
// 1 twenty-four-hour) is written through csr_wr_en/csr_wr_data; the user must
// write it only while the core is idle, as the block does not enforce this.
module bcd_alarm_clock_core
   import bclk_pkg::*;
#(
   parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // alarm_sel[1:0], hours_reg[9:2], minutes_reg[17:10], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // display_high[7:0], display_low[15:8], colon_flag[16], pm_flag[17],
   // auto_flag[18], buzzer_fire[22:19], radio_fire[26:23],
   // write_hours[32:27], write_minutes[39:33]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // write_valid[0]
   output logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   logic     q_full, q_push, q_pop, q_valid;
   item_type push_item, pop_item;
   rsp_type  rsp;

   // Accept and classify
   bclk_front #(
      .ALARM_COUNT (ALARM_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // Decouple intake from execution
   bclk_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (pop_item)
   );

   // Execute against the alarm state
   bclk_back #(
      .ALARM_COUNT (ALARM_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (pop_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = rsp.data;
   assign rsp_tuser = rsp.write_valid;

endmodule

[design/bclk_checker.sv]
// Port-level checks on the response channel of the BCD alarm clock core,
// bound to the top level. Depends on bclk_pkg.
module bclk_checker
   import bclk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   rsp_data_type d;
   assign d = rsp_tdata;

   // Stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Write-back results carry no display or fire bits
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         d.display_high == '0 && d.display_low == '0 && !d.colon_flag && !d.pm_flag &&
         !d.auto_flag && d.buzzer_fire == '0 && d.radio_fire == '0)
      else $error("write-back result has display fields set");

   // Display results carry no write-back time
   a_disp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> d.write_hours == '0 && d.write_minutes == '0)
      else $error("display result has write-back fields set");

   // A display without colon is an alarm mode view
   a_mode_view: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && !d.colon_flag |->
         d.display_high == DISP_MODE_TAG && !d.pm_flag &&
         d.buzzer_fire == '0 && d.radio_fire == '0)
      else $error("mode view result malformed");

endmodule

bind bcd_alarm_clock_core bclk_checker u_checker (.*);

[sim/tb_bcd_alarm_clock_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bcd_alarm_clock_core: random and directed actions in,
// every response compared against a local model of the alarm table and display format.
// Depends on bclk_pkg and the core RTL only.
module tb_bcd_alarm_clock_core;
   import bclk_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int N_ALARMS       = 4;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTS     = 60;
   localparam int PHASE_ITEMS    = 360;
   localparam int N_PHASES       = 5;

   // Alarm mode encoding and the codes shown for each mode
   typedef enum logic [1:0] {
      ALM_OFF    = 2'd0,
      ALM_BUZZER = 2'd1,
      ALM_RADIO  = 2'd2
   } alarm_mode_type;

   localparam logic [7:0] CODE_OFF    = 8'h00;
   localparam logic [7:0] CODE_BUZZER = 8'h0B;
   localparam logic [7:0] CODE_RADIO  = 8'h0F;

   // BCD limits used for formatting and stepping
   localparam logic [7:0] HOUR_MAX      = 8'h23;
   localparam logic [7:0] MINUTE_MAX    = 8'h59;
   localparam logic [7:0] NOON          = 8'h12;
   localparam logic [7:0] HOURS_PER_DAY = 8'h24;
   localparam logic [7:0] EIGHT_PM      = 8'h20;
   localparam logic [7:0] NINE_PM       = 8'h21;
   localparam logic [7:0] PM_SKIP       = 8'h18;
   localparam logic [7:0] BCD_ADJUST    = 8'h06;

   typedef struct {
      op_type     op;
      logic [1:0] idx;
      logic [7:0] hr;
      logic [7:0] mn;
   } action_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [MODE_W-1:0]     req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;

   action_type pending_actions[$];
   rsp_type    expected_rsp[$];

   // Model state: alarm table, last raw time and display format
   logic [7:0]     alm_hour   [N_ALARMS] = '{default: 8'h00};
   logic [7:0]     alm_minute [N_ALARMS] = '{default: 8'h00};
   alarm_mode_type alm_mode   [N_ALARMS] = '{default: ALM_OFF};
   logic [7:0]     last_hour   = 8'h00;
   logic [7:0]     last_minute = 8'h00;
   logic           fmt_24h     = 1'b0;

   // Alarm times as they will stand once every queued action has run
   logic [7:0] plan_hour   [N_ALARMS] = '{default: 8'h00};
   logic [7:0] plan_minute [N_ALARMS] = '{default: 8'h00};

   logic req_taken    = 1'b0;
   logic idle_on      = 1'b1;
   int   req_gap      = 0;
   int   rsp_stall    = 0;
   int   error_count  = 0;
   int   queued_count = 0;
   int   stall_cycles = 0;

   bcd_alarm_clock_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Decimal-adjust a BCD value and wrap it to zero past the limit
   function automatic logic [7:0] bcd_settle(logic [7:0] v, logic [7:0] limit);
      logic [7:0] s;
      s = v;
      if (s[3:0] >= 4'hA) s = s + BCD_ADJUST;
      if (s > limit) s = 8'h00;
      return s;
   endfunction

   // Format a time for the display in the current hour form
   function automatic rsp_data_type shown_time(logic [7:0] h, logic [7:0] m);
      rsp_data_type d;
      d = '0;
      if (fmt_24h) begin
         if (h >= HOURS_PER_DAY) h = 8'h00;
      end else begin
         if (h >= NOON) d.pm_flag = 1'b1;
         if (h == 8'h00) begin
            h = NOON;
         end else if (h > NOON) begin
            if (h == EIGHT_PM || h == NINE_PM) h = h - PM_SKIP;
            else h = h - NOON;
         end
      end
      if (m > MINUTE_MAX) m = 8'h00;
      d.display_high = h;
      d.display_low  = m;
      d.colon_flag   = 1'b1;
      for (int i = 0; i < N_ALARMS; i++)
         if (alm_mode[i] != ALM_OFF) d.auto_flag = 1'b1;
      return d;
   endfunction

   // Apply one action to the model state and return the response it yields
   function automatic rsp_type alarm_clock_action(op_type op, logic [1:0] idx,
                                                  logic [7:0] hr_raw, logic [7:0] mn_raw);
      rsp_type        r;
      logic [7:0]     hr;
      logic [7:0]     mn;
      alarm_mode_type md;
      r  = '0;
      hr = {2'b00, hr_raw[5:0]};
      mn = {1'b0, mn_raw[6:0]};
      case (op)
         OP_TIME_READ: begin
            r.data = shown_time(hr, mn);
            // fire on a match only when both hour and minute moved since the last read
            for (int i = 0; i < N_ALARMS; i++) begin
               if (alm_mode[i] != ALM_OFF && alm_hour[i] == hr && alm_hour[i] != last_hour &&
                   alm_minute[i] == mn && alm_minute[i] != last_minute) begin
                  if (alm_mode[i] == ALM_BUZZER) r.data.buzzer_fire[i] = 1'b1;
                  else r.data.radio_fire[i] = 1'b1;
               end
            end
            last_hour   = hr;
            last_minute = mn;
         end
         OP_ALM_HOUR_UP: begin
            alm_hour[idx] = bcd_settle(alm_hour[idx] + 8'h01, HOUR_MAX);
            r.data = shown_time(alm_hour[idx], alm_minute[idx]);
         end
         OP_ALM_MIN_UP: begin
            alm_minute[idx] = bcd_settle(alm_minute[idx] + 8'h01, MINUTE_MAX);
            r.data = shown_time(alm_hour[idx], alm_minute[idx]);
         end
         OP_ALM_MODE_UP, OP_ALM_MODE_DOWN: begin
            md = alm_mode[idx];
            if (op == OP_ALM_MODE_UP) md = (md == ALM_RADIO) ? ALM_OFF : alarm_mode_type'(md + 1);
            else md = (md == ALM_OFF) ? ALM_RADIO : alarm_mode_type'(md - 1);
            alm_mode[idx] = md;
            r.data.display_high = DISP_MODE_TAG;
            r.data.display_low  = (md == ALM_OFF) ? CODE_OFF :
                                  (md == ALM_BUZZER) ? CODE_BUZZER : CODE_RADIO;
            r.data.auto_flag    = (md != ALM_OFF);
         end
         OP_ALM_VIEW: begin
            r.data = shown_time(alm_hour[idx], alm_minute[idx]);
         end
         default: begin
            // time increments: both fields pass through the BCD correction
            r.write_valid = 1'b1;
            if (op == OP_TIME_HOUR_UP) begin
               hr = hr + 8'h01;
            end else begin
               mn = mn + 8'h01;
            end
            r.data.write_hours   = 6'(bcd_settle(hr, HOUR_MAX) & 8'h3F);
            r.data.write_minutes = 7'(bcd_settle(mn, MINUTE_MAX) & 8'h7F);
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got_v, logic [7:0] want_v);
      if (error_count < MAX_PRINTS)
         $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got_v, want_v);
      error_count++;
   endtask

   // Queue one action and track where it leaves the alarm times
   task automatic add_action(op_type op, logic [1:0] idx, logic [7:0] hr, logic [7:0] mn);
      action_type a;
      a.op  = op;
      a.idx = idx;
      a.hr  = hr;
      a.mn  = mn;
      pending_actions.push_back(a);
      if (op == OP_ALM_HOUR_UP) plan_hour[idx] = bcd_settle(plan_hour[idx] + 8'h01, HOUR_MAX);
      if (op == OP_ALM_MIN_UP)
         plan_minute[idx] = bcd_settle(plan_minute[idx] + 8'h01, MINUTE_MAX);
      queued_count++;
   endtask

   // Hold until every queued transaction has gone through and its response came back;
   // sample at the rising edge, where the request valid is settled
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_actions.size() != 0 || req_tvalid || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_format(logic fmt);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      fmt_24h = fmt;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Request driver: present the next action, with random idle bursts
   always @(negedge clock) begin : drive_req
      action_type            a;
      logic [REQ_DATA_W-1:0] d;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_tvalid <= 1'b0;
            req_gap = $urandom_range(1, 16) - 1;
         end else if (pending_actions.size() != 0) begin
            a = pending_actions.pop_front();
            d = '0;
            d[IDX_IN_W-1:0]         = a.idx;
            d[HOURS_LSB +: REG_W]   = a.hr;
            d[MINUTES_LSB +: REG_W] = a.mn;
            req_tvalid <= 1'b1;
            req_tdata  <= d;
            req_tuser  <= a.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response backpressure in random bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = $urandom_range(1, 16) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on request acceptance, check on response acceptance
   always @(posedge clock) begin : observe
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_rsp.push_back(alarm_clock_action(op_type'(req_tuser),
                                                      req_tdata[IDX_IN_W-1:0],
                                                      req_tdata[HOURS_LSB +: REG_W],
                                                      req_tdata[MINUTES_LSB +: REG_W]));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with nothing outstanding", got.data.display_high, 8'h00);
            end else begin
               want = expected_rsp.pop_front();
               if (got.write_valid !== want.write_valid)
                  report_mismatch("write_valid", 8'(got.write_valid), 8'(want.write_valid));
               if (got.data.display_high !== want.data.display_high)
                  report_mismatch("display_high", got.data.display_high, want.data.display_high);
               if (got.data.display_low !== want.data.display_low)
                  report_mismatch("display_low", got.data.display_low, want.data.display_low);
               if (got.data.colon_flag !== want.data.colon_flag)
                  report_mismatch("colon_flag", 8'(got.data.colon_flag),
                                  8'(want.data.colon_flag));
               if (got.data.pm_flag !== want.data.pm_flag)
                  report_mismatch("pm_flag", 8'(got.data.pm_flag), 8'(want.data.pm_flag));
               if (got.data.auto_flag !== want.data.auto_flag)
                  report_mismatch("auto_flag", 8'(got.data.auto_flag), 8'(want.data.auto_flag));
               if (got.data.buzzer_fire !== want.data.buzzer_fire)
                  report_mismatch("buzzer_fire", 8'(got.data.buzzer_fire),
                                  8'(want.data.buzzer_fire));
               if (got.data.radio_fire !== want.data.radio_fire)
                  report_mismatch("radio_fire", 8'(got.data.radio_fire),
                                  8'(want.data.radio_fire));
               if (got.data.write_hours !== want.data.write_hours)
                  report_mismatch("write_hours", 8'(got.data.write_hours),
                                  8'(want.data.write_hours));
               if (got.data.write_minutes !== want.data.write_minutes)
                  report_mismatch("write_minutes", 8'(got.data.write_minutes),
                                  8'(want.data.write_minutes));
            end
         end
      end
   end

   // Watchdog: drop out when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int r;
      int j;
      int start_count;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, every action, mode wrap and both firing kinds
      add_action(OP_TIME_READ,     2'd0, 8'hFF, 8'hFF);
      add_action(OP_ALM_MODE_DOWN, 2'd0, 8'h00, 8'h00);
      add_action(OP_ALM_MODE_UP,   2'd0, 8'h00, 8'h00);
      add_action(OP_ALM_MODE_UP,   2'd1, 8'h00, 8'h00);
      add_action(OP_ALM_HOUR_UP,   2'd1, 8'h00, 8'h00);
      add_action(OP_ALM_MIN_UP,    2'd1, 8'h00, 8'h00);
      add_action(OP_TIME_READ,     2'd2, 8'h01, 8'h01);
      add_action(OP_TIME_READ,     2'd3, 8'hC1, 8'h81);
      add_action(OP_ALM_VIEW,      2'd1, 8'hFF, 8'hFF);
      add_action(OP_ALM_MODE_UP,   2'd1, 8'h00, 8'h00);
      add_action(OP_TIME_READ,     2'd0, 8'h00, 8'h00);
      add_action(OP_TIME_READ,     2'd0, 8'h01, 8'h01);
      add_action(OP_TIME_READ,     2'd1, 8'h12, 8'h30);
      add_action(OP_TIME_READ,     2'd1, 8'h13, 8'h59);
      add_action(OP_TIME_READ,     2'd1, 8'h20, 8'h60);
      add_action(OP_TIME_READ,     2'd1, 8'h21, 8'h00);
      add_action(OP_TIME_READ,     2'd1, 8'h24, 8'h05);
      add_action(OP_TIME_HOUR_UP,  2'd0, 8'h23, 8'h00);
      add_action(OP_TIME_HOUR_UP,  2'd3, 8'h09, 8'h5A);
      add_action(OP_TIME_HOUR_UP,  2'd2, 8'h3F, 8'h7F);
      add_action(OP_TIME_MIN_UP,   2'd0, 8'h00, 8'h59);
      add_action(OP_TIME_MIN_UP,   2'd1, 8'h2A, 8'h09);
      add_action(OP_TIME_MIN_UP,   2'd3, 8'hFF, 8'h7F);
      add_action(OP_ALM_MODE_DOWN, 2'd3, 8'h00, 8'h00);
      add_action(OP_ALM_MODE_DOWN, 2'd3, 8'h00, 8'h00);
      wait_idle();

      // Random phases, alternating hour form; some phases run without idling
      for (int phase = 0; phase < N_PHASES; phase++) begin
         write_format(phase[0] == 1'b0);
         idle_on = (phase != 2 && phase != N_PHASES - 1);
         start_count = queued_count;
         while (queued_count - start_count < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            j = $urandom_range(0, N_ALARMS - 1);
            if (r < 30) begin
               // move the clock away, then land on an alarm's time
               add_action(OP_TIME_READ, 2'($urandom), 8'($urandom), 8'($urandom));
               add_action(OP_TIME_READ, 2'($urandom),
                          plan_hour[j] | {2'($urandom), 6'h00},
                          plan_minute[j] | {1'($urandom), 7'h00});
            end else if (r < 45) begin
               add_action(OP_TIME_READ, 2'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 57) begin
               add_action(OP_ALM_HOUR_UP, 2'(j), 8'($urandom), 8'($urandom));
            end else if (r < 69) begin
               add_action(OP_ALM_MIN_UP, 2'(j), 8'($urandom), 8'($urandom));
            end else if (r < 77) begin
               add_action(OP_ALM_MODE_UP, 2'(j), 8'($urandom), 8'($urandom));
            end else if (r < 83) begin
               add_action(OP_ALM_MODE_DOWN, 2'(j), 8'($urandom), 8'($urandom));
            end else if (r < 89) begin
               add_action(OP_ALM_VIEW, 2'(j), 8'($urandom), 8'($urandom));
            end else if (r < 95) begin
               add_action(OP_TIME_HOUR_UP, 2'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               add_action(OP_TIME_MIN_UP, 2'($urandom), 8'($urandom), 8'($urandom));
            end
         end
         wait_idle();
      end

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/bclk_pkg.sv
design/bclk_front.sv
design/bclk_fifo.sv
design/bclk_back.sv
design/bcd_alarm_clock_core.sv
design/bclk_checker.sv
sim/tb_bcd_alarm_clock_core.sv
